// ===== src/edst_pkg.sv =====
// Shared types and constants for the earliest-deadline slot timer.
// Holds the command and result beat structs and the command codes.
// No dependencies.
package edst_pkg;

    localparam int TIME_W = 48;
    localparam int SLOT_W = 4;
    localparam int CMD_W  = 2;
    localparam int CFG_W  = 5;

    localparam logic [CMD_W-1:0] CMD_ARM    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DISARM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FIRE   = 2'd2;

    localparam logic [TIME_W-1:0] RELOAD_FLOOR_US = 48'd1;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [SLOT_W-1:0] slot;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] now;
    } t_cmd_beat;

    typedef struct packed {
        logic              fired;
        logic [SLOT_W-1:0] fired_slot;
        logic [TIME_W-1:0] timer_delay;
        logic              bad_slot;
    } t_rsp_beat;

endpackage

// ===== src/edst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Used for the per-slot deadline store. No dependencies.
module edst_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/earliest_deadline_slot_timer.sv =====
// Top level of the earliest-deadline slot timer.
// Depends on edst_pkg for beat types and command codes, and on edst_ram.
//
// Each command beat is taken when start is high and busy is low, and then
// passes through S_UPD, which applies an arm or disarm, S_SCAN, a serial
// scan through the single read port of the deadline RAM, and S_FIRE, which
// settles the fire and computes the reload delay. The result beat appears on
// o_rsp for exactly one cycle with o_done high, in the cycle busy falls;
// the receiver cannot stall it, so it must be taken when shown.
module earliest_deadline_slot_timer
    import edst_pkg::*;
#(
    parameter int NUM_SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_cmd_beat        i_cmd,
    input  logic             i_cfg_we,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_done,
    output t_rsp_beat        o_rsp
);

    localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int LW = ($clog2(NUM_SLOTS + 1) > CFG_W) ? $clog2(NUM_SLOTS + 1) : CFG_W;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_UPD  = 4'b0010,
        S_SCAN = 4'b0100,
        S_FIRE = 4'b1000
    } t_state;

    t_state            r_state, n_state;
    t_cmd_beat         r_cmd;
    logic [CFG_W-1:0]  r_slots_in_use;
    logic [NUM_SLOTS-1:0] r_armed;
    logic [SW:0]       r_cnt;
    logic              r_cmp_vld;
    logic [SW-1:0]     r_cmp_idx;
    logic              r_have1, r_have2;
    logic [TIME_W-1:0] r_min1, r_min2;
    logic [SW-1:0]     r_idx1;
    logic              r_done;
    t_rsp_beat         r_rsp;

    logic [LW-1:0]     limit;
    logic [LW-1:0]     slot_ext;
    logic [LW-1:0]     idx1_ext;
    logic              slot_ok;
    logic              is_arm, is_disarm;
    logic              ram_we;
    logic [SW-1:0]     slot_addr;
    logic [SW-1:0]     rd_addr;
    logic [TIME_W-1:0] rd_data;
    logic              take_beat;
    logic              fire_now;
    logic              sel_have;
    logic [TIME_W-1:0] sel_time;
    logic [TIME_W:0]   diff;
    logic [TIME_W-1:0] delay;

    assign take_beat = start && (r_state == S_IDLE);
    assign busy      = (r_state != S_IDLE);

    assign limit = (LW'(r_slots_in_use) > LW'(NUM_SLOTS)) ? LW'(NUM_SLOTS)
                                                         : LW'(r_slots_in_use);
    assign slot_ext  = LW'(r_cmd.slot);
    assign slot_ok   = slot_ext < limit;
    assign slot_addr = slot_ext[SW-1:0];
    assign is_arm    = (r_cmd.command == CMD_ARM);
    assign is_disarm = (r_cmd.command == CMD_DISARM);
    assign ram_we    = (r_state == S_UPD) && is_arm && slot_ok;
    assign rd_addr   = r_cnt[SW-1:0];

    edst_ram #(
        .WIDTH (TIME_W),
        .DEPTH (NUM_SLOTS),
        .AW    (SW)
    ) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_addr),
        .i_wdata (r_cmd.deadline),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    assign fire_now = (r_cmd.command == CMD_FIRE) && r_have1 && (r_min1 < r_cmd.now);
    assign sel_have = fire_now ? r_have2 : r_have1;
    assign sel_time = fire_now ? r_min2 : r_min1;
    assign diff     = {1'b0, sel_time} - {1'b0, r_cmd.now};
    assign idx1_ext = LW'(r_idx1);

    always_comb begin
        if (!sel_have) begin
            delay = '0;
        end else if (diff[TIME_W] || (diff[TIME_W-1:0] == '0)) begin
            delay = RELOAD_FLOOR_US;
        end else begin
            delay = diff[TIME_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: n_state = S_SCAN;
            S_SCAN: begin
                if (r_cnt == (SW+1)'(NUM_SLOTS)) begin
                    n_state = S_FIRE;
                end
            end
            S_FIRE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_slots_in_use <= '0;
            r_armed        <= '0;
            r_cmp_vld      <= 1'b0;
            r_done         <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == S_FIRE);
            if (i_cfg_we) begin
                r_slots_in_use <= i_cfg_data;
            end
            if ((r_state == S_UPD) && slot_ok && (is_arm || is_disarm)) begin
                r_armed[slot_addr] <= is_arm;
            end
            if ((r_state == S_FIRE) && fire_now) begin
                r_armed[r_idx1] <= 1'b0;
            end
            r_cmp_vld <= (r_state == S_SCAN) && (r_cnt < (SW+1)'(NUM_SLOTS));
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_beat) begin
            r_cmd <= i_cmd;
        end
        r_cmp_idx <= rd_addr;
        if (r_state == S_UPD) begin
            r_cnt   <= '0;
            r_have1 <= 1'b0;
            r_have2 <= 1'b0;
        end else begin
            if (r_state == S_SCAN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_cmp_vld && r_armed[r_cmp_idx]) begin
                if (!r_have1 || (rd_data < r_min1)) begin
                    r_min2  <= r_min1;
                    r_have2 <= r_have1;
                    r_min1  <= rd_data;
                    r_idx1  <= r_cmp_idx;
                    r_have1 <= 1'b1;
                end else if (!r_have2 || (rd_data < r_min2)) begin
                    r_min2  <= rd_data;
                    r_have2 <= 1'b1;
                end
            end
        end
        if (r_state == S_FIRE) begin
            r_rsp.fired       <= fire_now;
            r_rsp.fired_slot  <= fire_now ? idx1_ext[SLOT_W-1:0] : '0;
            r_rsp.timer_delay <= delay;
            r_rsp.bad_slot    <= (is_arm || is_disarm) && !slot_ok;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
